@@ rtl/core/mcg_pkg.sv @@
`default_nettype none

package mcg_pkg;

	localparam int ENV_BITS = 25;
	localparam logic [ENV_BITS-1:0] ENV_ONE = 25'h100_0000;

	// quarter-wave polynomial coefficients, Q16
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [16:0] SIN_B = 17'd42048;
	localparam logic [16:0] SIN_C = 17'd4640;

	typedef struct packed {
		logic [23:0] beat_frames;
		logic [15:0] click_length;
		logic [31:0] track_length;
		logic [3:0]  channel_count;
		logic [31:0] phase_step;
		logic [23:0] envelope_step;
		logic [14:0] amplitude;
	} cfg_t;

	// one classified frame, handed from the front to the back
	typedef struct packed {
		logic                run;
		logic [31:0]         phase;
		logic [ENV_BITS-1:0] env;
		logic                past;
		logic [3:0]          chans;
	} job_t;

endpackage

`default_nettype wire

@@ rtl/core/mcg_front.sv @@
`default_nettype none

module mcg_front #(
	parameter int MAX_CHANNELS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mcg_pkg::cfg_t      cfg,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          restart,
	output logic               push_valid,
	input  wire logic          push_ready,
	output mcg_pkg::job_t      push_job
);
	import mcg_pkg::*;

	logic [31:0]         fp_q, fp, fp_nx;
	logic [23:0]         ip_q, ip, ip_nx;
	logic [24:0]         ip_inc;
	logic [15:0]         ci_q, ci, ci_s, ci_nx;
	logic [31:0]         ph_q, ph, ph_s, ph_nx;
	logic [ENV_BITS-1:0] env_q, env, env_s, env_nx;
	logic                run_q, run, run_s, run_nx;
	logic                past, start, accept;
	logic [23:0]         ivl;
	logic [15:0]         clen;
	logic [3:0]          cc, chans;

	assign accept     = in_valid && push_ready;
	assign in_stall   = !push_ready;
	assign push_valid = in_valid;

	always_comb begin
		ivl = (cfg.beat_frames == '0) ? 24'd1 : cfg.beat_frames;
		clen = (cfg.click_length == '0) ? 16'd1 : cfg.click_length;
		cc = (cfg.channel_count == '0) ? 4'd1 : cfg.channel_count;
		chans = ({1'b0, cc} > 5'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : cc;

		fp  = restart ? '0 : fp_q;
		ip  = restart ? '0 : ip_q;
		ci  = restart ? '0 : ci_q;
		ph  = restart ? '0 : ph_q;
		env = restart ? ENV_ONE : env_q;
		run = restart ? 1'b0 : run_q;

		past  = fp >= cfg.track_length;
		// a click starts only if it ends within the track
		start = !past && (ip == '0) &&
			(({1'b0, fp} + 33'(clen)) <= {1'b0, cfg.track_length});

		ci_s  = start ? '0 : ci;
		ph_s  = start ? '0 : ph;
		env_s = start ? ENV_ONE : env;
		run_s = (start || run) && !past;

		push_job.run   = run_s;
		push_job.phase = ph_s;
		push_job.env   = env_s;
		push_job.past  = past;
		push_job.chans = chans;

		ci_nx  = ci_s;
		ph_nx  = ph_s;
		env_nx = env_s;
		run_nx = run_s;
		if (run_s) begin
			ci_nx  = ci_s + 16'd1;
			ph_nx  = ph_s + cfg.phase_step;
			env_nx = (env_s > {1'b0, cfg.envelope_step}) ?
				env_s - {1'b0, cfg.envelope_step} : '0;
			run_nx = ci_nx < clen;
		end

		ip_inc = {1'b0, ip} + 25'd1;
		ip_nx  = (ip_inc >= {1'b0, ivl}) ? '0 : ip_inc[23:0];
		fp_nx  = (fp == '1) ? fp : fp + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q  <= '0;
			ip_q  <= '0;
			ci_q  <= '0;
			ph_q  <= '0;
			env_q <= ENV_ONE;
			run_q <= 1'b0;
		end else if (accept) begin
			fp_q  <= fp_nx;
			ip_q  <= ip_nx;
			ci_q  <= ci_nx;
			ph_q  <= ph_nx;
			env_q <= env_nx;
			run_q <= run_nx;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mcg_queue.sv @@
`default_nettype none

module mcg_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  mcg_pkg::job_t push_job,
	output logic          pop_valid,
	input  wire logic     pop,
	output mcg_pkg::job_t pop_job
);
	import mcg_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mcg_back.sv @@
`default_nettype none

module mcg_back #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int SAMPLE_BITS      = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  mcg_pkg::cfg_t             cfg,
	input  wire logic                 pop_valid,
	output logic                      pop,
	input  mcg_pkg::job_t             pop_job,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic [2:0]                channel,
	output logic                      last_channel,
	output logic                      past_end
);
	import mcg_pkg::*;

	// table depth is a power of two: the entry is the top phase bits
	localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
	localparam logic [31:0] IDX_MASK = ~((32'd1 << (32 - IDX_BITS)) - 32'd1);
	localparam int SH = 55 - SAMPLE_BITS;
	localparam logic [55:0] RND = 56'd1 << (SH - 1);
	localparam logic [SAMPLE_BITS:0] LIM = (SAMPLE_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_Z2   = 10'b00_0000_0010,
		ST_T1   = 10'b00_0000_0100,
		ST_T2   = 10'b00_0000_1000,
		ST_T3   = 10'b00_0001_0000,
		ST_MG   = 10'b00_0010_0000,
		ST_AM   = 10'b00_0100_0000,
		ST_V    = 10'b00_1000_0000,
		ST_FIN  = 10'b01_0000_0000,
		ST_HOLD = 10'b10_0000_0000
	} state_t;

	state_t                   state_q, state_nx;
	logic [54:0]              prod_q;
	logic [29:0]              mul_a;
	logic [24:0]              mul_b;
	logic [16:0]              z_q, z2_q, z_new;
	logic [15:0]              z_raw;
	logic [31:0]              p;
	logic [1:0]               quad_q;
	logic [ENV_BITS-1:0]      env_q;
	logic [24:0]              e2_q;
	logic [14:0]              mag_q, mag_nx;
	logic [17:0]              s_rnd;
	logic                     past_q;
	logic [3:0]               chans_q;
	logic [SAMPLE_BITS-1:0]   sample_q, fin_val;
	logic [55:0]              v_sum;
	logic [SAMPLE_BITS:0]     v_sh;
	logic [SAMPLE_BITS-1:0]   v_sat;

	logic                     em_busy_q, em_past_q;
	logic [SAMPLE_BITS-1:0]   em_sample_q;
	logic [3:0]               em_chans_q, em_ch_q;
	logic                     em_last, out_fire, load_ok, load;

	assign pop = (state_q == ST_IDLE) && pop_valid;

	always_comb begin
		p     = pop_job.phase & IDX_MASK;
		z_raw = p[29:14];
		z_new = p[30] ? 17'h1_0000 - {1'b0, z_raw} : {1'b0, z_raw};

		s_rnd  = {1'b0, prod_q[32:16]} + 18'd1;
		mag_nx = (s_rnd[17:1] > 17'd32767) ? 15'h7FFF : s_rnd[15:1];

		v_sum  = {1'b0, prod_q} + RND;
		v_sh   = v_sum[55:SH];
		v_sat  = (v_sh > LIM) ? LIM[SAMPLE_BITS-1:0] : v_sh[SAMPLE_BITS-1:0];
		fin_val = quad_q[1] ? SAMPLE_BITS'(0) - v_sat : v_sat;

		mul_a    = '0;
		mul_b    = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					state_nx = pop_job.run ? ST_Z2 : ST_HOLD;
				end
			end
			ST_Z2: begin
				mul_a    = 30'(z_q);
				mul_b    = 25'(z_q);
				state_nx = ST_T1;
			end
			ST_T1: begin
				mul_a    = 30'(prod_q[32:16]);
				mul_b    = 25'(SIN_C);
				state_nx = ST_T2;
			end
			ST_T2: begin
				mul_a    = 30'(z2_q);
				mul_b    = 25'(SIN_B - prod_q[32:16]);
				state_nx = ST_T3;
			end
			ST_T3: begin
				mul_a    = 30'(z_q);
				mul_b    = 25'(SIN_A - prod_q[32:16]);
				state_nx = ST_MG;
			end
			ST_MG: begin
				mul_a    = 30'(env_q);
				mul_b    = env_q;
				state_nx = ST_AM;
			end
			ST_AM: begin
				mul_a    = 30'(cfg.amplitude);
				mul_b    = 25'(mag_q);
				state_nx = ST_V;
			end
			ST_V: begin
				mul_a    = prod_q[29:0];
				mul_b    = e2_q;
				state_nx = ST_FIN;
			end
			ST_FIN: begin
				state_nx = ST_HOLD;
			end
			ST_HOLD: begin
				if (load_ok) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (pop) begin
			z_q      <= z_new;
			quad_q   <= p[31:30];
			env_q    <= pop_job.env;
			past_q   <= pop_job.past;
			chans_q  <= pop_job.chans;
			sample_q <= '0;
		end
		if (state_q == ST_T1) begin
			z2_q <= prod_q[32:16];
		end
		if (state_q == ST_MG) begin
			mag_q <= mag_nx;
		end
		if (state_q == ST_AM) begin
			e2_q <= prod_q[48:24];
		end
		if (state_q == ST_FIN) begin
			sample_q <= fin_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// channel emitter: repeats one finished sample across the channels
	assign em_last  = em_ch_q == (em_chans_q - 4'd1);
	assign out_fire = em_busy_q && !out_stall;
	assign load_ok  = !em_busy_q || (out_fire && em_last);
	assign load     = (state_q == ST_HOLD) && load_ok;

	always_ff @(posedge clk) begin
		if (load) begin
			em_sample_q <= sample_q;
			em_past_q   <= past_q;
			em_chans_q  <= chans_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q <= 1'b0;
			em_ch_q   <= '0;
		end else if (load) begin
			em_busy_q <= 1'b1;
			em_ch_q   <= '0;
		end else if (out_fire) begin
			if (em_last) begin
				em_busy_q <= 1'b0;
			end else begin
				em_ch_q <= em_ch_q + 4'd1;
			end
		end
	end

	assign out_valid    = em_busy_q;
	assign sample       = em_sample_q;
	assign channel      = em_ch_q[2:0];
	assign last_channel = em_last;
	assign past_end     = em_past_q;

`ifndef NO_ASSERTIONS
	a_ch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_busy_q |-> (em_ch_q < em_chans_q))
		else $error("channel index beyond channel count");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (em_busy_q && em_ch_q == 4'd0))
		else $error("handover did not start at channel zero");

	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !em_last) |=> (em_busy_q && em_ch_q == $past(em_ch_q) + 4'd1))
		else $error("frame dropped before its last channel");

	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && !load_ok) |=> (state_q == ST_HOLD && !$past(pop)))
		else $error("back left hold without handing over");
`endif

endmodule

`default_nettype wire

@@ rtl/core/metronome_click_generator_top.sv @@
// Metronome click generator.
// Input channel (in_valid / in_stall, field restart): one word per audio
// frame. restart returns the track to frame zero before the frame is made.
// Output channel (out_valid / out_stall): per frame, one word per channel
// with the frame's sample, channel index, last_channel on the final one and
// past_end once the track length is reached.
// Config: APB-style write/read port, seven 32-bit registers at 4*index.
// The front classifies a frame combinationally and parks it in a two-word
// queue. The back runs the sine polynomial and click gain through one
// shared multiplier, stepping through its multiply states for a frame
// inside a click and going straight to hold for a silent one; then the
// channel emitter sends one word per cycle while out_stall is low. The
// back works on the next frame while the emitter sends the previous one.
// A stalled receiver holds the current word; the emitter, back and queue
// fill up and then in_stall rises.
// Reset restores the register defaults, returns to frame zero and empties
// the queue and emitter.
`default_nettype none

module metronome_click_generator_top #(
	parameter int MAX_CHANNELS     = 8,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int SAMPLE_BITS      = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [4:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     restart,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic [2:0]                    channel,
	output logic                          last_channel,
	output logic                          past_end
);
	import mcg_pkg::*;

	typedef enum logic [2:0] {
		REG_INTERVAL = 3'd0,
		REG_CLICK    = 3'd1,
		REG_TRACK    = 3'd2,
		REG_CHANNELS = 3'd3,
		REG_PHASE    = 3'd4,
		REG_ENV      = 3'd5,
		REG_AMP      = 3'd6,
		REG_NONE     = 3'd7
	} reg_idx_t;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;
	logic     push_valid, push_ready, pop_valid, pop;
	job_t     push_job, pop_job;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_frames     <= 24'd24000;
			cfg_q.click_length    <= 16'd480;
			cfg_q.track_length    <= 32'd480000;
			cfg_q.channel_count   <= 4'd2;
			cfg_q.phase_step      <= 32'd89478485;
			cfg_q.envelope_step   <= 24'd34952;
			cfg_q.amplitude       <= 15'd16384;
		end else if (wr) begin
			unique case (idx)
				REG_INTERVAL: cfg_q.beat_frames     <= pwdata[23:0];
				REG_CLICK:    cfg_q.click_length    <= pwdata[15:0];
				REG_TRACK:    cfg_q.track_length    <= pwdata;
				REG_CHANNELS: cfg_q.channel_count   <= pwdata[3:0];
				REG_PHASE:    cfg_q.phase_step      <= pwdata;
				REG_ENV:      cfg_q.envelope_step   <= pwdata[23:0];
				REG_AMP:      cfg_q.amplitude       <= pwdata[14:0];
				REG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INTERVAL: prdata = {8'd0, cfg_q.beat_frames};
			REG_CLICK:    prdata = {16'd0, cfg_q.click_length};
			REG_TRACK:    prdata = cfg_q.track_length;
			REG_CHANNELS: prdata = {28'd0, cfg_q.channel_count};
			REG_PHASE:    prdata = cfg_q.phase_step;
			REG_ENV:      prdata = {8'd0, cfg_q.envelope_step};
			REG_AMP:      prdata = {17'd0, cfg_q.amplitude};
			REG_NONE:     prdata = '0;
			default:      prdata = '0;
		endcase
	end

	mcg_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job)
	);

	mcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job)
	);

	mcg_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (pop_valid),
		.pop         (pop),
		.pop_job     (pop_job),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample      (sample),
		.channel     (channel),
		.last_channel(last_channel),
		.past_end    (past_end)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_metronome_click_generator_top.sv @@
`default_nettype none

module tb_metronome_click_generator_top;

	import mcg_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_CH      = 8;
	localparam int GAIN_SHIFT  = 39 + 16 - SAMPLE_BITS;
	localparam int IDLE_PCT    = 38;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	typedef enum int {
		REG_INTERVAL   = 0,
		REG_CLICK_LEN  = 1,
		REG_TRACK_LEN  = 2,
		REG_CHANNELS   = 3,
		REG_PHASE_STEP = 4,
		REG_ENV_STEP   = 5,
		REG_AMPLITUDE  = 6
	} reg_e;

	typedef struct packed {
		logic signed [15:0] level;
		logic [2:0]         chan;
		logic               last;
		logic               past;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0, restart = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [2:0]  channel;
	logic        last_channel, past_end;

	// register copies
	logic [23:0] cfg_interval;
	logic [15:0] cfg_clen;
	logic [31:0] cfg_track;
	logic [3:0]  cfg_chans;
	logic [31:0] cfg_step;
	logic [23:0] cfg_env_step;
	logic [14:0] cfg_amp;

	// track state
	logic [31:0] frame_pos;
	logic [23:0] ivl_pos;
	logic [15:0] click_idx;
	logic [31:0] tone_ph;
	logic [24:0] env_lvl;
	logic        clicking;

	bit    pending_frames[$];
	word_t expected_words[$];
	bit    steady = 1'b0;
	int    errors = 0;
	int    frames_taken = 0;
	int    words_seen = 0;
	int    settings_used = 1;
	int    cycles = 0;

	metronome_click_generator_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample(sample), .channel(channel), .last_channel(last_channel),
		.past_end(past_end)
	);

	always #4 clk = ~clk;

	function automatic void rewind_track();
		frame_pos = '0;
		ivl_pos   = '0;
		click_idx = '0;
		tone_ph   = '0;
		env_lvl   = ENV_ONE;
		clicking  = 1'b0;
	endfunction

	// quarter-wave polynomial on the table entry picked by the top 10 phase bits
	function automatic int table_sine(input logic [31:0] ph);
		logic [1:0]  quad;
		logic [63:0] z, z2, s;
		quad = ph[31:30];
		z = {48'd0, ph[29:22], 8'd0};
		if (quad[0])
			z = 64'd65536 - z;
		z2 = (z * z) >> 16;
		s = 64'(SIN_B) - ((z2 * 64'(SIN_C)) >> 16);
		s = 64'(SIN_A) - ((z2 * s) >> 16);
		s = (z * s) >> 16;
		s = (s + 64'd1) >> 1;
		if (s > 64'd32767)
			s = 64'd32767;
		return quad[1] ? -int'(s) : int'(s);
	endfunction

	function automatic logic [15:0] click_level(input int sn, input logic [24:0] env,
			input logic [14:0] amp);
		logic [63:0] mag, e2, v;
		mag = (sn < 0) ? 64'(-sn) : 64'(sn);
		e2 = (64'(env) * 64'(env)) >> 24;
		v = 64'(amp) * mag * e2;
		v = (v + (64'd1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
		if (v > 64'd32767)
			v = 64'd32767;
		return (sn < 0) ? 16'(64'd0 - v) : 16'(v);
	endfunction

	// one frame of the track; queues a word per channel
	function automatic void advance_frame(input logic rst);
		logic [24:0] ivl;
		logic [16:0] clen;
		int          chans;
		logic [15:0] lvl;
		logic        past;
		word_t       w;
		ivl   = (cfg_interval == 0) ? 25'd1 : 25'(cfg_interval);
		clen  = (cfg_clen == 0) ? 17'd1 : 17'(cfg_clen);
		chans = (cfg_chans == 0) ? 1 : ((cfg_chans > MAX_CH) ? MAX_CH : int'(cfg_chans));
		lvl   = '0;
		if (rst)
			rewind_track();
		past = frame_pos >= cfg_track;
		if (!past && ivl_pos == 0 && (33'(frame_pos) + 33'(clen) <= 33'(cfg_track))) begin
			click_idx = '0;
			tone_ph   = '0;
			env_lvl   = ENV_ONE;
			clicking  = 1'b1;
		end
		if (past)
			clicking = 1'b0;
		if (clicking) begin
			lvl = click_level(table_sine(tone_ph), env_lvl, cfg_amp);
			tone_ph = tone_ph + cfg_step;
			env_lvl = (env_lvl > 25'(cfg_env_step)) ? env_lvl - 25'(cfg_env_step) : '0;
			click_idx = click_idx + 16'd1;
			if (17'(click_idx) >= clen)
				clicking = 1'b0;
		end
		if (25'(ivl_pos) + 25'd1 >= ivl)
			ivl_pos = '0;
		else
			ivl_pos = ivl_pos + 24'd1;
		if (frame_pos != 32'hFFFF_FFFF)
			frame_pos = frame_pos + 32'd1;
		for (int ch = 0; ch < chans; ch++) begin
			w.level = lvl;
			w.chan  = 3'(ch);
			w.last  = (ch == chans - 1);
			w.past  = past;
			expected_words.push_back(w);
		end
	endfunction

	task automatic reg_write(input reg_e idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(int'(idx) * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_INTERVAL:   cfg_interval = val[23:0];
			REG_CLICK_LEN:  cfg_clen     = val[15:0];
			REG_TRACK_LEN:  cfg_track    = val;
			REG_CHANNELS:   cfg_chans    = val[3:0];
			REG_PHASE_STEP: cfg_step     = val;
			REG_ENV_STEP:   cfg_env_step = val[23:0];
			REG_AMPLITUDE:  cfg_amp      = val[14:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(input logic [31:0] ivl, input logic [31:0] clen,
			input logic [31:0] track, input logic [31:0] chans, input logic [31:0] step,
			input logic [31:0] env_step, input logic [31:0] amp);
		reg_write(REG_INTERVAL, ivl);
		reg_write(REG_CLICK_LEN, clen);
		reg_write(REG_TRACK_LEN, track);
		reg_write(REG_CHANNELS, chans);
		reg_write(REG_PHASE_STEP, step);
		reg_write(REG_ENV_STEP, env_step);
		reg_write(REG_AMPLITUDE, amp);
		settings_used++;
	endtask

	task automatic queue_frames(input int count, input int restart_pct, input bit first_restart);
		for (int i = 0; i < count; i++)
			pending_frames.push_back((i == 0 && first_restart) ||
				($urandom_range(0, 99) < restart_pct));
	endtask

	task automatic drain();
		while (pending_frames.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	// frame driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart  <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_frame(restart);
				frames_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_frames.size() != 0 &&
						(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					restart  <= pending_frames.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// word monitor
	always @(posedge clk) begin
		word_t got, want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.level = sample;
				got.chan  = channel;
				got.last  = last_channel;
				got.past  = past_end;
				words_seen++;
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: sample %0d ch %0d last %0b past %0b",
							got.level, got.chan, got.last, got.past);
				end else begin
					want = expected_words.pop_front();
					if (got.level !== want.level || got.chan !== want.chan ||
							got.last !== want.last || got.past !== want.past) begin
						errors++;
						if (errors <= 10)
							$display({"word %0d mismatch: exp sample %0d ch %0d last %0b",
								" past %0b, got sample %0d ch %0d last %0b past %0b"},
								words_seen, want.level, want.chan, want.last, want.past,
								got.level, got.chan, got.last, got.past);
					end
				end
			end
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				expected_words.size());
			$display("tb_metronome_click_generator_top failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] ivl, clen, track;
		cfg_interval = 24'd24000;
		cfg_clen     = 16'd480;
		cfg_track    = 32'd480000;
		cfg_chans    = 4'd2;
		cfg_step     = 32'd89478485;
		cfg_env_step = 24'd34952;
		cfg_amp      = 15'd16384;
		rewind_track();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// power-on settings: click at frame zero
		queue_frames(2, 0, 1'b0);
		drain();
		// zero interval, zero click length, zero channels, short track runs past end
		load_setting(0, 0, 5, 0, 32'hFFFF_FFFF, 24'hFF_FFFF, 32767);
		queue_frames(7, 0, 1'b1);
		drain();
		// clicks overlap, quarter-turn phase steps, channel count saturates
		load_setting(3, 5, 32'hFFFF_FFFF, 15, 32'h4000_0000, 0, 32767);
		queue_frames(7, 0, 1'b1);
		drain();
		// interval shrinks below the running interval position
		load_setting(100, 4, 1000, 8, 32'h0100_0000, 24'h40_0000, 0);
		queue_frames(6, 0, 1'b1);
		drain();
		reg_write(REG_INTERVAL, 2);
		queue_frames(3, 0, 1'b0);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p == 5) begin
				ivl   = 32'h00FF_FFFF;
				clen  = 32'd65535;
				track = 32'hFFFF_FFFF;
			end else begin
				ivl   = $urandom_range(1, 12);
				clen  = ($urandom_range(0, 99) < 25) ? $urandom_range(0, 20)
					: $urandom_range(1, ivl);
				track = $urandom_range(0, 90);
			end
			load_setting(ivl, clen, track, $urandom_range(0, 15), $urandom,
				$urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 12),
				$urandom_range(0, 32767));
			steady = (p == 2);
			queue_frames(70, (p == 5) ? 10 : 5, 1'b1);
			drain();
			steady = 1'b0;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d frames and %0d channel words over %0d register settings",
			frames_taken, words_seen, settings_used);
		$display("mismatches: %0d, words left waiting: %0d", errors, expected_words.size());
		if (errors == 0 && expected_words.size() == 0)
			$display("tb_metronome_click_generator_top passed");
		else
			$display("tb_metronome_click_generator_top failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/mcg_pkg.sv
rtl/core/mcg_front.sv
rtl/core/mcg_queue.sv
rtl/core/mcg_back.sv
rtl/core/metronome_click_generator_top.sv
tb/sv/tb_metronome_click_generator_top.sv
